// ===== sv/encoder_velocity_filter_top_macros.svh =====
// Assertion helpers shared by the velocity filter RTL.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef ENCODER_VELOCITY_FILTER_TOP_MACROS_SVH
`define ENCODER_VELOCITY_FILTER_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define EVF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define EVF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/evf_pkg.sv =====
`timescale 1ns / 1ps

package evf_pkg;

    // Default counter width and fixed field widths
    localparam int COUNTER_WIDTH_DEF = 16;
    localparam int COEF_FRAC         = 15;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 24;
    localparam int MUL_A_W           = 34;
    localparam int MUL_B_W           = 25;
    localparam int PROD_W            = MUL_A_W + MUL_B_W;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_RPM_SCALE          = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_FEEDBACK    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_FEEDFORWARD = 2'd2;

    // Configuration reset values
    localparam logic [23:0] RPM_SCALE_RST          = 24'd65536;
    localparam logic [14:0] FILTER_FEEDBACK_RST    = 15'd27984;
    localparam logic [14:0] FILTER_FEEDFORWARD_RST = 15'd2386;

    // Microprogram step addresses
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_WAIT    = 3'd0;
    localparam logic [STEP_W-1:0] STEP_MUL_RAW = 3'd1;
    localparam logic [STEP_W-1:0] STEP_SAT_RAW = 3'd2;
    localparam logic [STEP_W-1:0] STEP_ACC_FB  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_FINISH  = 3'd4;

    // Multiplier operand select
    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_RAW,
        MUL_FB,
        MUL_FF
    } evf_mul_t;

    // One microcode word
    typedef struct packed {
        logic              in_rdy;
        logic              hold_out;
        evf_mul_t          mul_sel;
        logic              ld_raw;
        logic              ld_acc;
        logic              commit;
        logic              br_in;
        logic [STEP_W-1:0] tgt_t;
        logic [STEP_W-1:0] tgt_f;
    } evf_uword_t;

    // Datapath strobes, already gated by the sequencer
    typedef struct packed {
        logic     ld_in;
        evf_mul_t mul_sel;
        logic     ld_raw;
        logic     ld_acc;
        logic     commit;
    } evf_ctl_t;

    // Control store
    function automatic evf_uword_t evf_ucode(input logic [STEP_W-1:0] step);
        evf_uword_t w;
        w = '{in_rdy: 1'b0, hold_out: 1'b0, mul_sel: MUL_NONE, ld_raw: 1'b0,
              ld_acc: 1'b0, commit: 1'b0, br_in: 1'b0,
              tgt_t: STEP_WAIT, tgt_f: STEP_WAIT};
        case (step)
            STEP_WAIT:
            begin
                w.in_rdy = 1'b1;
                w.br_in  = 1'b1;
                w.tgt_t  = STEP_MUL_RAW;
                w.tgt_f  = STEP_WAIT;
            end
            STEP_MUL_RAW:
            begin
                w.mul_sel = MUL_RAW;
                w.tgt_t   = STEP_SAT_RAW;
            end
            STEP_SAT_RAW:
            begin
                w.ld_raw  = 1'b1;
                w.mul_sel = MUL_FB;
                w.tgt_t   = STEP_ACC_FB;
            end
            STEP_ACC_FB:
            begin
                w.ld_acc  = 1'b1;
                w.mul_sel = MUL_FF;
                w.tgt_t   = STEP_FINISH;
            end
            STEP_FINISH:
            begin
                w.hold_out = 1'b1;
                w.commit   = 1'b1;
                w.in_rdy   = 1'b1;
                w.br_in    = 1'b1;
                w.tgt_t    = STEP_MUL_RAW;
                w.tgt_f    = STEP_WAIT;
            end
            default:
            begin
                w.tgt_t = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
        localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;
        logic signed [31:0] r;
        if (v > SAT_MAX)
            r = 32'sh7FFF_FFFF;
        else if (v < SAT_MIN)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== sv/evf_datapath.sv =====
`timescale 1ns / 1ps

module evf_datapath
    import evf_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  evf_ctl_t           ctl,
    input  logic [15:0]        counter_value,
    input  logic [23:0]        rpm_scale,
    input  logic [14:0]        filter_feedback,
    input  logic [14:0]        filter_feedforward,
    output logic signed [16:0] count_delta,
    output logic signed [31:0] raw_velocity,
    output logic signed [31:0] filtered_velocity
);

    localparam int DW = COUNTER_WIDTH + 1;
    localparam logic signed [DW-1:0] HALF     = {2'b01, {(COUNTER_WIDTH-1){1'b0}}};
    localparam logic signed [DW-1:0] NEG_HALF = -HALF;

    logic [COUNTER_WIDTH-1:0] last_count_reg;
    logic signed [31:0]       prev_raw_reg;
    logic signed [31:0]       y_reg;
    logic signed [DW-1:0]     delta_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [31:0]       raw_reg;
    logic signed [31:0]       acc_reg;
    logic signed [16:0]       out_delta_reg;
    logic signed [31:0]       out_raw_reg;
    logic signed [31:0]       out_y_reg;

    logic [31:0]              cv_ext;
    logic [COUNTER_WIDTH-1:0] now;
    logic signed [DW-1:0]     diff;
    logic signed [DW-1:0]     delta_next;
    logic signed [32:0]       ff_sum;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_shift;
    logic signed [31:0]       raw_next;
    logic signed [31:0]       acc_next;
    logic signed [31:0]       y_next;
    logic signed [MUL_A_W-1:0] delta_wide;

    // Form the wrapped count change; half-range changes keep their sign
    always_comb
    begin
        cv_ext = {16'b0, counter_value};
        now    = cv_ext[COUNTER_WIDTH-1:0];
        diff   = $signed({1'b0, now}) - $signed({1'b0, last_count_reg});
        if (diff > HALF || diff < NEG_HALF)
            delta_next = {~diff[COUNTER_WIDTH], diff[COUNTER_WIDTH-1:0]};
        else
            delta_next = diff;
    end

    // Select operands of the shared multiplier
    always_comb
    begin
        ff_sum = 33'(raw_reg) + 33'(prev_raw_reg);
        mul_a  = '0;
        mul_b  = '0;
        case (ctl.mul_sel)
            MUL_RAW:
            begin
                mul_a = MUL_A_W'(delta_reg);
                mul_b = $signed({1'b0, rpm_scale});
            end
            MUL_FB:
            begin
                mul_a = MUL_A_W'(y_reg);
                mul_b = $signed({10'b0, filter_feedback});
            end
            MUL_FF:
            begin
                mul_a = MUL_A_W'(ff_sum);
                mul_b = $signed({10'b0, filter_feedforward});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Scale, accumulate and saturate from the product register
    always_comb
    begin
        prod_shift = prod_reg >>> COEF_FRAC;
        raw_next   = sat32(64'(prod_reg));
        acc_next   = prod_shift[31:0];
        y_next     = sat32(64'(acc_reg) + 64'(prod_shift));
        delta_wide = MUL_A_W'(delta_reg);
    end

    // Hold filter state across items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= '0;
            prev_raw_reg   <= '0;
            y_reg          <= '0;
        end
        else
        begin
            if (ctl.ld_in)
                last_count_reg <= now;
            if (ctl.commit)
            begin
                prev_raw_reg <= raw_reg;
                y_reg        <= y_next;
            end
        end
    end

    // Advance working and output registers
    always_ff @(posedge clk)
    begin
        if (ctl.ld_in)
            delta_reg <= delta_next;
        if (ctl.mul_sel != MUL_NONE)
            prod_reg <= prod_next;
        if (ctl.ld_raw)
            raw_reg <= raw_next;
        if (ctl.ld_acc)
            acc_reg <= acc_next;
        if (ctl.commit)
        begin
            out_delta_reg <= delta_wide[16:0];
            out_raw_reg   <= raw_reg;
            out_y_reg     <= y_next;
        end
    end

    assign count_delta       = out_delta_reg;
    assign raw_velocity      = out_raw_reg;
    assign filtered_velocity = out_y_reg;

endmodule

// ===== sv/encoder_velocity_filter_top.sv =====
`timescale 1ns / 1ps
// Encoder velocity filter: takes one free-running counter sample per item and returns
// the wrapped count change, the raw velocity (change times rpm_scale, signed Q16.16,
// saturated) and a first-order IIR filtered velocity. A five-word microprogram steps
// one shared 34 x 25 multiplier through the raw scaling, the feedback product and the
// feedforward product and the final step registers the result. A new item is taken only
// in the wait step or in the final step, in the same cycle that the previous result is
// registered. The result register holds a finished item while the next one is worked on;
// the final step waits only while that register is still full and stalled. The user must
// write configuration through cfg_valid / cfg_ready only while the block is idle, which
// the block itself does not enforce; indexes past the last register are ignored.

`include "encoder_velocity_filter_top_macros.svh"

module encoder_velocity_filter_top
    import evf_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [15:0]            counter_value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [16:0]     count_delta,
    output logic signed [31:0]     raw_velocity,
    output logic signed [31:0]     filtered_velocity,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [STEP_W-1:0] pc_reg;
    logic [STEP_W-1:0] pc_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [23:0]       rpm_scale_reg;
    logic [14:0]       feedback_reg;
    logic [14:0]       feedforward_reg;

    evf_uword_t uw;
    evf_ctl_t   ctl;
    logic       out_busy;
    logic       held;
    logic       in_taken;
    logic       out_taken;

    // Decode the current control word
    always_comb
    begin
        uw        = evf_ucode(pc_reg);
        out_busy  = out_valid_reg && out_stall;
        held      = uw.hold_out && out_busy;
        in_stall  = !(uw.in_rdy && !held);
        in_taken  = in_valid && !in_stall;
        out_taken = out_valid_reg && !out_stall;

        ctl.ld_in   = in_taken;
        ctl.mul_sel = held ? MUL_NONE : uw.mul_sel;
        ctl.ld_raw  = uw.ld_raw && !held;
        ctl.ld_acc  = uw.ld_acc && !held;
        ctl.commit  = uw.commit && !held;

        if (held)
            pc_next = pc_reg;
        else if (uw.br_in)
            pc_next = in_taken ? uw.tgt_t : uw.tgt_f;
        else
            pc_next = uw.tgt_t;

        if (ctl.commit)
            out_valid_next = 1'b1;
        else if (out_taken)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Advance the step counter and result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpm_scale_reg   <= RPM_SCALE_RST;
            feedback_reg    <= FILTER_FEEDBACK_RST;
            feedforward_reg <= FILTER_FEEDFORWARD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RPM_SCALE:          rpm_scale_reg   <= cfg_data;
                CFG_FILTER_FEEDBACK:    feedback_reg    <= cfg_data[14:0];
                CFG_FILTER_FEEDFORWARD: feedforward_reg <= cfg_data[14:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    evf_datapath #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctl                (ctl),
        .counter_value      (counter_value),
        .rpm_scale          (rpm_scale_reg),
        .filter_feedback    (feedback_reg),
        .filter_feedforward (feedforward_reg),
        .count_delta        (count_delta),
        .raw_velocity       (raw_velocity),
        .filtered_velocity  (filtered_velocity)
    );

    `EVF_ASSERT_IMPL(a_pc_in_program, 1'b1, pc_reg <= STEP_FINISH, "step counter left the program")
    `EVF_ASSERT_IMPL(a_take_at_entry, in_taken, pc_reg == STEP_WAIT || pc_reg == STEP_FINISH, "item taken mid-sequence")
    `EVF_ASSERT_NEXT(a_take_starts, in_taken, pc_reg == STEP_MUL_RAW, "taken item did not start the sequence")
    `EVF_ASSERT_NEXT(a_finish_posts, pc_reg == STEP_FINISH && !out_busy, out_valid_reg, "finished item not posted")

endmodule
